// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the key/value table RTL.
// Expects signals clk and rst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds on every clock edge out of reset.
`define KVT_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// Check that a condition implies a consequence in the same cycle.
`define KVT_ASSERT_IMPLY(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("assertion failed");

// Check that a condition implies a consequence in the next cycle.
`define KVT_ASSERT_NEXT(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/kvt_pkg.sv =====
// Shared codes and types for the key/value table.
// No dependencies; used by kvt_cell and key_value_table.
package kvt_pkg;

    localparam int KEY_W   = 32;
    localparam int VALUE_W = 64;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 3;
    localparam int COUNT_W = 7;

    localparam logic [CMD_W-1:0] CMD_PUT    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_GET    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

    localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STAT_W-1:0] ST_UPDATED   = 3'd1;
    localparam logic [STAT_W-1:0] ST_FOUND     = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STAT_W-1:0] ST_DELETED   = 3'd4;
    localparam logic [STAT_W-1:0] ST_CLEARED   = 3'd5;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd6;

    // Broadcast controls from the sequencer to every cell
    typedef struct packed {
        logic match_en;
        logic update;
        logic insert;
        logic remove;
        logic clear;
    } kvt_ctrl_t;

endpackage

// ===== rtl/kvt_cell.sv =====
// One entry of the key/value table: key, value, valid and match flags.
// Depends on kvt_pkg; instantiated in a chain by key_value_table.
module kvt_cell
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  kvt_pkg::kvt_ctrl_t              ctrl,
    input  logic signed [kvt_pkg::KEY_W-1:0]   key_in,
    input  logic        [kvt_pkg::VALUE_W-1:0] value_in,
    input  logic                            prev_valid,
    input  logic signed [kvt_pkg::KEY_W-1:0]   next_key,
    input  logic        [kvt_pkg::VALUE_W-1:0] next_value,
    input  logic                            next_valid,
    input  logic                            seen_in,
    input  logic        [kvt_pkg::VALUE_W-1:0] rd_in,
    output logic signed [kvt_pkg::KEY_W-1:0]   key_out,
    output logic        [kvt_pkg::VALUE_W-1:0] value_out,
    output logic                            valid_out,
    output logic                            match_out,
    output logic                            seen_out,
    output logic        [kvt_pkg::VALUE_W-1:0] rd_out
);
    import kvt_pkg::*;

    logic signed [KEY_W-1:0]   key_reg, key_next;
    logic        [VALUE_W-1:0] value_reg, value_next;
    logic                      valid_reg, valid_next;
    logic                      match_reg, match_next;

    // Seen is high from the matching entry upwards: those entries shift down
    assign seen_out  = seen_in | match_reg;
    assign rd_out    = rd_in | (match_reg ? value_reg : '0);
    assign key_out   = key_reg;
    assign value_out = value_reg;
    assign valid_out = valid_reg;
    assign match_out = match_reg;

    always_comb
    begin
        key_next   = key_reg;
        value_next = value_reg;
        valid_next = valid_reg;
        match_next = match_reg;
        if (ctrl.match_en)
        begin
            match_next = valid_reg && (key_reg == key_in);
        end
        if (ctrl.update && match_reg)
        begin
            value_next = value_in;
        end
        if (ctrl.insert && !valid_reg && prev_valid)
        begin
            key_next   = key_in;
            value_next = value_in;
            valid_next = 1'b1;
        end
        if (ctrl.remove && seen_out)
        begin
            key_next   = next_key;
            value_next = next_value;
            valid_next = next_valid;
        end
        if (ctrl.clear)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            match_reg <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

endmodule

// ===== rtl/key_value_table.sv =====
// Top level of the key/value table: command sequencer and chain of entry cells.
// Depends on kvt_pkg, kvt_cell and assert_macros.svh.
//
//  channel | direction | handshake            | words
//  in      | input     | in_valid / in_ready   | command, key, value_in
//  out     | output    | out_valid / out_ready | status, value_out, entry_count
//
// Every cell registers its key compare at the accept edge, and the
// put/get/delete/clear action lands with the result on the next edge. The next
// command is taken in the cycle its predecessor's result is taken; no command
// is accepted while one executes.
// Reset clears the valid flags and the entry count; no clearing pass is needed.
// A stalled result holds the block: no command is accepted until it is taken.
module key_value_table
#(
    parameter int CAPACITY = 64
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic        [kvt_pkg::CMD_W-1:0]     command,
    input  logic signed [kvt_pkg::KEY_W-1:0]     key,
    input  logic        [kvt_pkg::VALUE_W-1:0]   value_in,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic        [kvt_pkg::STAT_W-1:0]    status,
    output logic        [kvt_pkg::VALUE_W-1:0]   value_out,
    output logic        [kvt_pkg::COUNT_W-1:0]   entry_count
);
    import kvt_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_OUT  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [CMD_W-1:0]        cmd_reg;
    logic signed [KEY_W-1:0] key_reg;
    logic [VALUE_W-1:0]      value_reg;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [STAT_W-1:0]       status_reg, status_next;
    logic [VALUE_W-1:0]      rdata_reg, rdata_next;
    logic [CNT_W+COUNT_W-1:0] count_ext;

    kvt_ctrl_t ctrl;
    logic      accept;
    logic      any_match;
    logic      full;

    // Chain wires seen_chain and rd_chain: index i feeds cell i, i+1 comes out of it.
    logic signed [KEY_W-1:0]   cell_key   [CAPACITY];
    logic        [VALUE_W-1:0] cell_value [CAPACITY];
    logic [CAPACITY-1:0]       valid_vec;
    logic [CAPACITY-1:0]       match_vec;
    logic [CAPACITY:0]         seen_chain;
    logic [VALUE_W-1:0]        rd_chain [CAPACITY+1];

    assign seen_chain[0] = 1'b0;
    assign rd_chain[0]   = '0;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic signed [KEY_W-1:0]   nk;
            logic        [VALUE_W-1:0] nv;
            logic                      nvld;
            logic                      pvld;

            if (gi == CAPACITY - 1)
            begin : g_last
                assign nk   = '0;
                assign nv   = '0;
                assign nvld = 1'b0;
            end
            else
            begin : g_mid
                assign nk   = cell_key[gi+1];
                assign nv   = cell_value[gi+1];
                assign nvld = valid_vec[gi+1];
            end

            if (gi == 0)
            begin : g_first
                assign pvld = 1'b1;
            end
            else
            begin : g_rest
                assign pvld = valid_vec[gi-1];
            end

            kvt_cell u_cell
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .key_in     (accept ? key : key_reg),
                .value_in   (value_reg),
                .prev_valid (pvld),
                .next_key   (nk),
                .next_value (nv),
                .next_valid (nvld),
                .seen_in    (seen_chain[gi]),
                .rd_in      (rd_chain[gi]),
                .key_out    (cell_key[gi]),
                .value_out  (cell_value[gi]),
                .valid_out  (valid_vec[gi]),
                .match_out  (match_vec[gi]),
                .seen_out   (seen_chain[gi+1]),
                .rd_out     (rd_chain[gi+1])
            );
        end
    endgenerate

    // Keys are unique in the table, so the end of the seen chain is "any match"
    assign any_match = seen_chain[CAPACITY];
    assign full      = valid_vec[CAPACITY-1];

    assign in_ready = (state_reg == S_IDLE) || ((state_reg == S_OUT) && out_ready);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        ctrl          = '0;
        ctrl.match_en = accept;
        count_next    = count_reg;
        status_next   = status_reg;
        rdata_next    = rdata_reg;
        state_next    = state_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_OUT;
                rdata_next = '0;
                unique case (cmd_reg)
                    CMD_PUT:
                    begin
                        if (any_match)
                        begin
                            ctrl.update = 1'b1;
                            status_next = ST_UPDATED;
                        end
                        else if (full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            ctrl.insert = 1'b1;
                            count_next  = count_reg + 1'b1;
                            status_next = ST_INSERTED;
                        end
                    end
                    CMD_GET:
                    begin
                        if (any_match)
                        begin
                            rdata_next  = rd_chain[CAPACITY];
                            status_next = ST_FOUND;
                        end
                        else
                        begin
                            status_next = ST_NOT_FOUND;
                        end
                    end
                    CMD_DELETE:
                    begin
                        if (any_match)
                        begin
                            ctrl.remove = 1'b1;
                            count_next  = count_reg - 1'b1;
                            status_next = ST_DELETED;
                        end
                        else
                        begin
                            status_next = ST_NOT_FOUND;
                        end
                    end
                    CMD_CLEAR:
                    begin
                        ctrl.clear  = 1'b1;
                        count_next  = '0;
                        status_next = ST_CLEARED;
                    end
                    default:
                    begin
                        status_next = ST_NOT_FOUND;
                    end
                endcase
            end
            S_OUT:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
                else if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        rdata_reg  <= rdata_next;
        if (accept)
        begin
            cmd_reg   <= command;
            key_reg   <= key;
            value_reg <= value_in;
        end
    end

    assign count_ext   = {{COUNT_W{1'b0}}, count_reg};
    assign out_valid   = (state_reg == S_OUT);
    assign status      = status_reg;
    assign value_out   = rdata_reg;
    assign entry_count = count_ext[COUNT_W-1:0];

`include "assert_macros.svh"

    `KVT_ASSERT_ALWAYS(a_match_unique, $onehot0(match_vec))
    `KVT_ASSERT_ALWAYS(a_count_matches_valid, $countones(valid_vec) == count_reg)
    `KVT_ASSERT_IMPLY(a_valid_packed, !valid_vec[0], valid_vec == '0)
    `KVT_ASSERT_NEXT(a_exec_to_result, state_reg == S_EXEC, out_valid)

endmodule
